>>> rtl/rmth_pkg.sv
`timescale 1ns / 1ps
package rmth_pkg;
  localparam int SampleBits = 16;
  localparam int Capacity = 1024;
  localparam int HeapDepth = Capacity / 2 + 1;
  localparam int AddrBits = 10;
  localparam int CntBits = 10;
  localparam int TotBits = 11;

  typedef logic signed [SampleBits-1:0] smp_t;
  typedef logic [AddrBits-1:0] addr_t;
  typedef logic [CntBits-1:0] cnt_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PUSH_RD, ST_PUSH_CMP, ST_POP_RD, ST_POP_RD2, ST_POP_CMP,
    ST_DONE, ST_OUT
  } state_t;

  typedef enum logic [2:0] {C_IDLE, C_INS, C_BAL, C_POPW, C_PUSH2, C_WAIT, C_RES}
    cst_t;

  // One heap operation request from the controller.
  typedef struct packed {
    logic start_push;
    logic start_pop;
    logic heap_sel;   // 0 lower (max), 1 upper (min)
    smp_t value;
  } cmd_t;

  typedef struct packed {
    logic busy;
    smp_t popped;
  } sts_t;
endpackage

>>> rtl/rmth_heap_dp.sv
`timescale 1ns / 1ps
module rmth_heap_dp
  import rmth_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  cmd_t cmd,
  output sts_t sts,
  output cnt_t lo_cnt,
  output cnt_t up_cnt,
  output smp_t lo_top,
  output smp_t up_top
);
  smp_t lo_mem [HeapDepth];
  smp_t up_mem [HeapDepth];
  smp_t lo_top_r, up_top_r;
  cnt_t lo_cnt_r, up_cnt_r;
  state_t st_r;
  logic sel_r;
  addr_t idx_r, ra_r, rb_r;
  smp_t val_r, da_r, db_r, pop_r;
  cnt_t n_r;

  logic wr_en; addr_t wr_a; smp_t wr_d;
  logic rd_en; addr_t rd_a;
  smp_t rdata_r;

  logic [CntBits:0] l_w, r_w;
  logic lv, rv, takel, taker;
  smp_t best;

  function automatic logic above(smp_t a, smp_t b, logic mn);
    above = mn ? (a < b) : (a > b);
  endfunction

  always_ff @(posedge clk) begin
    if (wr_en && !sel_r) lo_mem[wr_a] <= wr_d;
    if (wr_en && sel_r) up_mem[wr_a] <= wr_d;
    if (rd_en) rdata_r <= sel_r ? up_mem[rd_a] : lo_mem[rd_a];
  end

  // Sift value val_r: push walks up, pop walks down, one level at a time.
  always_comb begin
    wr_en = 1'b0; wr_a = idx_r; wr_d = val_r;
    rd_en = 1'b0; rd_a = ra_r;
    case (st_r)
      ST_PUSH_RD: begin rd_en = 1'b1; rd_a = ra_r; end
      ST_PUSH_CMP: begin
        wr_en = 1'b1;
        if (idx_r != '0 && above(val_r, rdata_r, sel_r)) wr_d = rdata_r;
      end
      ST_POP_RD: begin rd_en = 1'b1; rd_a = ra_r; end
      ST_DONE: begin rd_en = 1'b1; rd_a = rb_r; end
      ST_POP_CMP: begin
        wr_en = 1'b1;
        if (n_r != '0 && (takel || taker)) wr_d = taker ? rdata_r : da_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    l_w = {idx_r, 1'b1};
    r_w = l_w + 1'b1;
    lv = l_w < {1'b0, n_r};
    rv = r_w < {1'b0, n_r};
    takel = lv && above(da_r, val_r, sel_r);
    best = takel ? da_r : val_r;
    taker = rv && above(rdata_r, best, sel_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; lo_cnt_r <= '0; up_cnt_r <= '0;
    end else begin
      case (st_r)
        ST_IDLE: begin
          if (cmd.start_push) begin
            sel_r <= cmd.heap_sel; val_r <= cmd.value;
            idx_r <= cmd.heap_sel ? up_cnt_r[AddrBits-1:0] : lo_cnt_r[AddrBits-1:0];
            ra_r <= cmd.heap_sel ? addr_t'((up_cnt_r - 1'b1) >> 1)
                                 : addr_t'((lo_cnt_r - 1'b1) >> 1);
            if (cmd.heap_sel) up_cnt_r <= up_cnt_r + 1'b1;
            else lo_cnt_r <= lo_cnt_r + 1'b1;
            st_r <= ST_PUSH_RD;
          end else if (cmd.start_pop) begin
            sel_r <= cmd.heap_sel;
            pop_r <= cmd.heap_sel ? up_top_r : lo_top_r;
            n_r <= (cmd.heap_sel ? up_cnt_r : lo_cnt_r) - 1'b1;
            if (cmd.heap_sel) up_cnt_r <= up_cnt_r - 1'b1;
            else lo_cnt_r <= lo_cnt_r - 1'b1;
            ra_r <= cmd.heap_sel ? addr_t'(up_cnt_r - 1'b1) : addr_t'(lo_cnt_r - 1'b1);
            idx_r <= '0;
            val_r <= '0;
            st_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          rb_r <= ra_r; st_r <= ST_POP_RD;
        end
        ST_PUSH_RD: st_r <= ST_PUSH_CMP;
        ST_PUSH_CMP: begin
          if (idx_r != '0 && above(val_r, rdata_r, sel_r)) begin
            idx_r <= ra_r;
            ra_r <= addr_t'((ra_r - 1'b1) >> 1);
            st_r <= ST_PUSH_RD;
          end else begin
            if (idx_r == '0) begin
              if (sel_r) up_top_r <= val_r; else lo_top_r <= val_r;
            end
            st_r <= ST_IDLE;
          end
        end
        ST_POP_RD: st_r <= ST_POP_RD2;
        ST_POP_RD2: begin
          if (rb_r != '1) begin
            val_r <= rdata_r; rb_r <= '1;
            ra_r <= addr_t'(l_w); st_r <= ST_POP_RD;
          end else begin
            da_r <= rdata_r; rb_r <= addr_t'(r_w);
            st_r <= ST_DONE;
          end
        end
        ST_DONE: st_r <= ST_POP_CMP;
        ST_POP_CMP: begin
          if (n_r == '0) st_r <= ST_IDLE;
          else if (takel || taker) begin
            idx_r <= taker ? addr_t'(r_w) : addr_t'(l_w);
            ra_r <= taker ? addr_t'({r_w, 1'b1}) : addr_t'({l_w, 1'b1});
            rb_r <= '1;
            st_r <= ST_POP_RD;
            if (idx_r == '0) begin
              if (sel_r) up_top_r <= best == val_r ? rdata_r : (taker ? rdata_r : da_r);
              else lo_top_r <= taker ? rdata_r : da_r;
            end
          end else begin
            if (idx_r == '0) begin
              if (sel_r) up_top_r <= val_r; else lo_top_r <= val_r;
            end
            st_r <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  // Pop sequence: ST_OUT -> RD(last) -> RD2 loads val, then per level RD(l) -> RD2 da ->
  // DONE reads r -> CMP.
  always_comb begin
    sts.busy = st_r != ST_IDLE;
    sts.popped = pop_r;
  end
  assign lo_cnt = lo_cnt_r;
  assign up_cnt = up_cnt_r;
  assign lo_top = lo_top_r;
  assign up_top = up_top_r;
endmodule

>>> rtl/rmth_ctrl.sv
`timescale 1ns / 1ps
module rmth_ctrl
  import rmth_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  smp_t in_sample,
  output logic out_tvalid,
  input  logic out_tready,
  output logic [31:0] out_tdata,
  output cmd_t cmd,
  input  sts_t sts,
  input  cnt_t lo_cnt,
  input  cnt_t up_cnt,
  input  smp_t lo_top,
  input  smp_t up_top
);
  cst_t st_r, st_nxt;
  logic ok_r, ok_nxt, ov_r, ov_nxt;
  smp_t s_r, s_nxt;
  logic [31:0] od_r, od_nxt;
  logic bsel_r, bsel_nxt;

  logic [TotBits-1:0] tot;
  logic signed [SampleBits:0] sum;
  smp_t med;
  always_comb begin
    tot = {1'b0, lo_cnt} + {1'b0, up_cnt};
    sum = {lo_top[SampleBits-1], lo_top} + {up_top[SampleBits-1], up_top};
    if (lo_cnt == '0) med = '0;
    else if (lo_cnt > up_cnt || up_cnt == '0) med = lo_top;
    else med = smp_t'((sum + {{SampleBits{1'b0}}, sum[SampleBits]}) >>> 1);
  end

  always_comb begin
    st_nxt = st_r; ok_nxt = ok_r; s_nxt = s_r; od_nxt = od_r; ov_nxt = ov_r;
    bsel_nxt = bsel_r;
    cmd = '0;
    in_tready = 1'b0;
    case (st_r)
      C_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          s_nxt = in_sample;
          ok_nxt = tot < TotBits'(Capacity);
          st_nxt = ok_nxt ? C_INS : C_RES;
        end
      end
      C_INS: begin
        cmd.start_push = 1'b1;
        cmd.heap_sel = !(lo_cnt == '0 || s_r <= med);
        cmd.value = s_r;
        st_nxt = C_WAIT;
        bsel_nxt = 1'b0;
      end
      C_WAIT: if (!sts.busy) st_nxt = bsel_r ? C_RES : C_BAL;
      C_BAL: begin
        if (up_cnt > lo_cnt) begin
          cmd.start_pop = 1'b1; cmd.heap_sel = 1'b1; st_nxt = C_POPW;
        end else if (lo_cnt == up_cnt + 2'd2) begin
          cmd.start_pop = 1'b1; cmd.heap_sel = 1'b0; st_nxt = C_POPW;
        end else st_nxt = C_RES;
        bsel_nxt = !cmd.heap_sel;
      end
      C_POPW: if (!sts.busy) st_nxt = C_PUSH2;
      C_PUSH2: begin
        cmd.start_push = 1'b1; cmd.heap_sel = bsel_r; cmd.value = sts.popped;
        bsel_nxt = 1'b1;
        st_nxt = C_WAIT;
      end
      C_RES: begin
        if (!ov_r || out_tready) begin
          od_nxt = {4'b0, ok_r, tot, med};
          ov_nxt = 1'b1;
          st_nxt = C_IDLE;
        end
      end
      default: st_nxt = C_IDLE;
    endcase
    if (ov_r && out_tready && !(st_r == C_RES)) ov_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= C_IDLE; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; ov_r <= ov_nxt;
    end
    ok_r <= ok_nxt; s_r <= s_nxt; od_r <= od_nxt; bsel_r <= bsel_nxt;
  end
  assign out_tvalid = ov_r;
  assign out_tdata = od_r;
endmodule

>>> rtl/running_median_two_heaps.sv
// out_tvalid rises once an accepted item's push, and any rebalancing pop and second push,
// have sifted through the heaps; a dropped item goes straight to its result.
// One item is handled at a time, taken in the cycle after the previous result is registered;
// a push sifts up one heap level at a time, a pop sifts down one level at a time.
// A result held back by out_tready stalls only the following result, not the next item.
// Reset (rst_n low, synchronous) empties both heaps and drops any pending result.
`timescale 1ns / 1ps
module running_median_two_heaps
  import rmth_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic [15:0] in_tdata,  // [15:0] sample
  output logic out_tvalid,
  input  logic out_tready,
  output logic [31:0] out_tdata  // [15:0] median_value, [26:16] sample_count, [27] accepted
);
  cmd_t cmd;
  sts_t sts;
  cnt_t lo_cnt, up_cnt;
  smp_t lo_top, up_top;

  rmth_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_sample(smp_t'(in_tdata)),
    .out_tvalid, .out_tready, .out_tdata, .cmd, .sts, .lo_cnt, .up_cnt,
    .lo_top, .up_top
  );
  rmth_heap_dp u_dp (
    .clk, .rst_n, .cmd, .sts, .lo_cnt, .up_cnt, .lo_top, .up_top
  );
endmodule

>>> rtl/rmth_checker.sv
`timescale 1ns / 1ps
module rmth_checker (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready,
  input logic [31:0] out_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)) else $error("hold");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[26:16] != 11'd0) else $error("count");
  a_nin: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready) else $error("one item");
  a_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[27] |-> out_tdata[26:16] == 11'd1024) else $error("drop");
endmodule

bind running_median_two_heaps rmth_checker u_chk (.*);

>>> test/running_median_two_heaps_tb.sv
`timescale 1ns / 1ps
module running_median_two_heaps_tb;
  import rmth_pkg::*;

  localparam int RandItems = 1900;
  localparam int CycleLimit = 900000;

  typedef struct packed {
    logic        accepted;
    logic [10:0] count;
    smp_t        median;
  } median_res_t;

  typedef struct {
    smp_t        sample;
    logic        known;
    median_res_t res;
  } row_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [15:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [31:0] out_tdata;

  running_median_two_heaps dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  int lo_heap[$];
  int hi_heap[$];
  median_res_t pending_medians[$];
  median_res_t known_results[$];
  logic known_flags[$];
  int err_count;
  int cycles;
  int got_count;
  int dropped_count;
  bit stim_done;
  bit hold_long;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int median_now();
    if (lo_heap.size() == 0) begin
      return 0;
    end
    if (lo_heap.size() > hi_heap.size() || hi_heap.size() == 0) begin
      return lo_heap[0];
    end
    return (lo_heap[0] + hi_heap[0]) / 2;
  endfunction

  // Heaps are kept as sorted queues: lower descending, upper ascending.
  function automatic void lo_insert(int v);
    int i;
    i = 0;
    while (i < lo_heap.size() && lo_heap[i] > v) i++;
    lo_heap.insert(i, v);
  endfunction

  function automatic void hi_insert(int v);
    int i;
    i = 0;
    while (i < hi_heap.size() && hi_heap[i] < v) i++;
    hi_heap.insert(i, v);
  endfunction

  function automatic median_res_t predict_median(smp_t s);
    median_res_t r;
    int v;
    int sv;
    sv = s;
    r.accepted = 1'b0;
    if (lo_heap.size() + hi_heap.size() < Capacity) begin
      r.accepted = 1'b1;
      if (lo_heap.size() == 0 || sv <= median_now()) begin
        lo_insert(sv);
      end else begin
        hi_insert(sv);
      end
      if (hi_heap.size() > lo_heap.size()) begin
        v = hi_heap.pop_front();
        lo_insert(v);
      end else if (lo_heap.size() == hi_heap.size() + 2) begin
        v = lo_heap.pop_front();
        hi_insert(v);
      end
    end
    r.median = smp_t'(median_now());
    r.count = 11'(lo_heap.size() + hi_heap.size());
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %0s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    err_count++;
  endtask

  task automatic send_sample(smp_t s, logic known, median_res_t kres);
    median_res_t p;
    p = predict_median(s);
    if (known && p != kres) begin
      report_mismatch("table row", p, kres);
    end
    pending_medians.push_back(p);
    in_tvalid <= 1'b1;
    in_tdata <= s;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if ($urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 60) : $urandom_range(1, 3))
        @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      median_res_t g;
      median_res_t e;
      g = out_tdata[27:0];
      got_count++;
      if (pending_medians.size() == 0) begin
        report_mismatch("unexpected item", g, 0);
      end else begin
        e = pending_medians.pop_front();
        if (g.median !== e.median) report_mismatch("median_value", $signed(g.median), $signed(e.median));
        if (g.count !== e.count) report_mismatch("sample_count", g.count, e.count);
        if (g.accepted !== e.accepted) report_mismatch("accepted", g.accepted, e.accepted);
        if (!e.accepted) dropped_count++;
      end
    end
  end

  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_long) begin
        out_tready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(0, 15) == 0 ? $urandom_range(10, 80) : $urandom_range(0, 2))
          @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout with %0d items outstanding", pending_medians.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    row_t rw;
    int n;
    smp_t s;
    cycles = 0;
    err_count = 0;
    got_count = 0;
    dropped_count = 0;
    stim_done = 1'b0;
    hold_long = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    rows.push_back('{16'sd5, 1'b1, '{1'b1, 11'd1, 16'sd5}});
    rows.push_back('{16'sd7, 1'b1, '{1'b1, 11'd2, 16'sd6}});
    rows.push_back('{16'sd6, 1'b1, '{1'b1, 11'd3, 16'sd6}});
    rows.push_back('{-16'sd32768, 1'b0, '0});
    rows.push_back('{16'sd32767, 1'b0, '0});
    rows.push_back('{-16'sd32768, 1'b0, '0});
    rows.push_back('{-16'sd32768, 1'b0, '0});
    rows.push_back('{-16'sd1, 1'b0, '0});
    rows.push_back('{16'sd0, 1'b0, '0});
    rows.push_back('{16'sd32767, 1'b0, '0});
    rows.push_back('{16'sd32767, 1'b0, '0});
    rows.push_back('{16'sd6, 1'b0, '0});
    rows.push_back('{16'sd6, 1'b0, '0});
    rows.push_back('{-16'sd3, 1'b0, '0});
    rows.push_back('{16'h5555, 1'b0, '0});
    rows.push_back('{16'shAAAA, 1'b0, '0});
    foreach (rows[i]) send_sample(rows[i].sample, rows[i].known, rows[i].res);
    in_tvalid <= 1'b0;
    while (pending_medians.size() != 0) @(posedge clk);

    // Fill storage past capacity; the output is held off at the start of this phase.
    fork
      begin
        hold_long = 1'b1;
        repeat (400) @(posedge clk);
        hold_long = 1'b0;
      end
    join_none
    n = 0;
    while (n < RandItems) begin
      case ($urandom_range(0, 3))
        0: s = smp_t'($urandom);
        1: s = smp_t'($urandom_range(0, 20)) - 16'sd10;
        2: s = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        default: s = smp_t'($urandom_range(0, 2000));
      endcase
      send_sample(s, 1'b0, '0);
      n++;
    end
    in_tvalid <= 1'b0;
    stim_done = 1'b1;
    while (pending_medians.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("Sent %0d samples; %0d results checked, %0d dropped at full storage.",
             rows.size() + RandItems, got_count, dropped_count);
    $display("Errors: %0d", err_count);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/rmth_pkg.sv
rtl/rmth_heap_dp.sv
rtl/rmth_ctrl.sv
rtl/running_median_two_heaps.sv
rtl/rmth_checker.sv
test/running_median_two_heaps_tb.sv
